### sv/sha256_byte_stream_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define SHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and the round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned SCHED_WORDS  = 16;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  round_t;
  typedef logic [2:0]  widx_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift;
    byte_sel_t sel;
    logic      count;
    logic      load;
    logic      round;
    round_t    round_idx;
    logic      finish;
    logic      restart;
    widx_t     word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_tail;
  } dp_stat_t;

  localparam word_t INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

### sv/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte shift window doubling as message schedule, round unit, hash state,
// bit counter and fill counter.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output sha256_pkg::dp_stat_t stat,
  output sha256_pkg::word_t    digest_word
);

  sha256_pkg::word_t window [sha256_pkg::SCHED_WORDS];
  sha256_pkg::word_t hash   [sha256_pkg::DIGEST_WORDS];
  sha256_pkg::word_t vars   [sha256_pkg::DIGEST_WORDS];
  logic [5:0]        fill;
  logic [63:0]       bits;

  logic [7:0]        byte_in;
  sha256_pkg::word_t w_next;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;

  always_comb begin
    case (cmd.sel)
      sha256_pkg::SEL_MSG:  byte_in = data_byte;
      sha256_pkg::SEL_MARK: byte_in = sha256_pkg::PAD_MARK;
      sha256_pkg::SEL_LEN:  byte_in = bits[63:56];
      default:              byte_in = 8'h00;
    endcase
  end

  assign w_next = window[15] + sha256_pkg::small_sig0(window[14]) + window[6]
                + sha256_pkg::small_sig1(window[1]);

  assign t1 = vars[7] + sha256_pkg::big_sig1(vars[4])
            + sha256_pkg::choose(vars[4], vars[5], vars[6])
            + sha256_pkg::ROUND_K[cmd.round_idx] + window[15];
  assign t2 = sha256_pkg::big_sig0(vars[0]) + sha256_pkg::majority(vars[0], vars[1], vars[2]);

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      window[0] <= {window[0][23:0], byte_in};
      for (int k = 1; k < sha256_pkg::SCHED_WORDS; k++) begin
        window[k] <= {window[k][23:0], window[k-1][31:24]};
      end
    end else if (cmd.round) begin
      window[0] <= w_next;
      for (int k = 1; k < sha256_pkg::SCHED_WORDS; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
        vars[i] <= hash[i];
      end
    end else if (cmd.round) begin
      vars[0] <= t1 + t2;
      vars[1] <= vars[0];
      vars[2] <= vars[1];
      vars[3] <= vars[2];
      vars[4] <= vars[3] + t1;
      vars[5] <= vars[4];
      vars[6] <= vars[5];
      vars[7] <= vars[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
        hash[i] <= sha256_pkg::INIT_HASH[i];
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      bits <= '0;
    end else if (cmd.count) begin
      bits <= bits + 64'd8;
    end else if (cmd.shift && cmd.sel == sha256_pkg::SEL_LEN) begin
      bits <= {bits[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.shift) begin
      fill <= fill + 6'd1;
    end
  end

  assign stat.fill_last = &fill;
  assign stat.fill_tail = &fill[5:3];
  assign digest_word    = hash[cmd.word_idx];

endmodule

### sv/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, the 64 rounds and the digest readout.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 byte_valid,
  input  logic                 end_of_message,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha256_pkg::widx_t    word_index,
  output logic                 last_word,
  output sha256_pkg::dp_cmd_t  cmd,
  input  sha256_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FINISH,
    S_PAD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_t;

  state_t             state, state_next;
  phase_t             phase, phase_next;
  sha256_pkg::round_t round_idx, round_next;
  sha256_pkg::widx_t  word_idx, word_next;
  logic               closing, closing_next;
  logic               final_blk, final_next;
  logic               in_acc;
  logic               out_acc;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_EMIT);
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign word_index = word_idx;
  assign last_word  = &word_idx;

  always_comb begin
    cmd           = '0;
    cmd.round_idx = round_idx;
    cmd.word_idx  = word_idx;
    state_next    = state;
    phase_next    = phase;
    round_next    = round_idx;
    word_next     = word_idx;
    closing_next  = closing;
    final_next    = final_blk;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_valid) begin
            cmd.shift = 1'b1;
            cmd.sel   = sha256_pkg::SEL_MSG;
            cmd.count = 1'b1;
            if (stat.fill_last) begin
              cmd.load     = 1'b1;
              state_next   = S_ROUND;
              round_next   = '0;
              closing_next = end_of_message;
              final_next   = 1'b0;
              phase_next   = PH_MARK;
            end else if (end_of_message) begin
              state_next = S_PAD;
              phase_next = PH_MARK;
            end
          end else if (end_of_message) begin
            state_next = S_PAD;
            phase_next = PH_MARK;
          end
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        round_next = round_idx + 6'd1;
        if (&round_idx) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (final_blk) begin
          state_next = S_EMIT;
          word_next  = '0;
        end else if (closing) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        unique case (phase)
          PH_MARK: begin
            cmd.sel    = sha256_pkg::SEL_MARK;
            phase_next = stat.fill_tail ? PH_ZERO : PH_LEN;
          end
          PH_ZERO: cmd.sel = sha256_pkg::SEL_ZERO;
          PH_LEN:  cmd.sel = stat.fill_tail ? sha256_pkg::SEL_LEN : sha256_pkg::SEL_ZERO;
          default: cmd.sel = sha256_pkg::SEL_ZERO;
        endcase
        if (stat.fill_last) begin
          cmd.load     = 1'b1;
          state_next   = S_ROUND;
          round_next   = '0;
          closing_next = 1'b1;
          final_next   = (phase == PH_LEN);
          phase_next   = PH_LEN;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          word_next = word_idx + 3'd1;
          if (&word_idx) begin
            cmd.restart  = 1'b1;
            state_next   = S_IDLE;
            closing_next = 1'b0;
            final_next   = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_MARK;
      round_idx <= '0;
      word_idx  <= '0;
      closing   <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      round_idx <= round_next;
      word_idx  <= word_next;
      closing   <= closing_next;
      final_blk <= final_next;
    end
  end

endmodule

### sv/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Throughput: one byte per cycle while in_ready is high; the 64th byte of a block
//   stalls intake while the single shared round unit runs the rounds of the block.
// Readout: after the end item, the padded tail is hashed, then 8 digest words follow.
// Reset: synchronous; hash state returns to the initial values, counts clear.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
  input logic        clk,
  input logic        rst,
  sha256_in_if.sink  msg,
  sha256_out_if.source digest
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (msg.valid),
    .byte_valid     (msg.byte_valid),
    .end_of_message (msg.end_of_message),
    .in_ready       (msg.ready),
    .out_valid      (digest.valid),
    .out_ready      (digest.ready),
    .word_index     (digest.word_index),
    .last_word      (digest.last_word),
    .cmd            (cmd),
    .stat           (stat)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .stat        (stat),
    .digest_word (digest.digest_word)
  );

endmodule

### sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Digest readout order and hand-back to message intake.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_top_macros.svh"

module sha256_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sha256_pkg::widx_t word_index,
  input logic              last_word
);

  `SHA_ASSERT_NOW(a_no_overlap, clk, rst, out_valid, !in_ready, "item taken during readout")
  `SHA_ASSERT_NOW(a_last_flag, clk, rst, out_valid, last_word == (word_index == 3'd7), "bad last")
  `SHA_ASSERT_NOW(a_first_word, clk, rst, $rose(out_valid), word_index == 3'd0, "bad first word")
  `SHA_ASSERT_NEXT(a_word_order, clk, rst, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "word skipped")
  `SHA_ASSERT_NEXT(a_back_idle, clk, rst, out_valid && out_ready && last_word, in_ready && !out_valid, "no return to intake")

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_sha256_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (msg.ready),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .word_index (digest.word_index),
  .last_word  (digest.last_word)
);
